// ===== rtl/assert_macros.svh =====
// Assertion macros, used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define HEQ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: check failed");

// A stalled item keeps valid high and its payload signal stable.
`define HEQ_ASSERT_HOLD(lbl, clk, rst_n, vld, stl, sig) \
  `HEQ_ASSERT(lbl, clk, rst_n, ((vld) && (stl)) |=> ((vld) && $stable(sig)))

`endif

// ===== rtl/heq_pkg.sv =====
package heq_pkg;

  localparam int MAX_PIXELS = 1048576;
  localparam int PIX_W      = 8;
  localparam int BINS       = 256;
  localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
  // cdf*510 + total fits in CNT_W+9 bits
  localparam int NUM_W      = CNT_W + 9;
  localparam int QUO_W      = 8;
  localparam int STEP_W     = $clog2(QUO_W);

  typedef enum logic [1:0] {
    OP_COUNT = 2'd0,
    OP_BUILD = 2'd1,
    OP_MAP   = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    BLD_IDLE,
    BLD_READ,
    BLD_ACC,
    BLD_MUL,
    BLD_DIV
  } bld_state_t;

  typedef struct packed {
    logic             en;
    logic [PIX_W-1:0] addr;
    logic [PIX_W-1:0] data;
  } map_wr_t;

  typedef struct packed {
    logic [PIX_W-1:0] eq;
    logic             sat;
  } res_t;

endpackage

// ===== rtl/heq_ram.sv =====
module heq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read-before-write on a same-address collision
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/heq_builder.sv =====
module heq_builder import heq_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [CNT_W-1:0] total,
  input  logic [CNT_W-1:0] bin_val,
  output logic             busy,
  output logic [PIX_W-1:0] bin_raddr,
  output map_wr_t          map_wr
);

  bld_state_t        state_r, state_nxt;
  logic [PIX_W-1:0]  g_r;
  logic [CNT_W-1:0]  run_r;
  logic [NUM_W-1:0]  rem_r;
  logic [QUO_W-1:0]  q_r;
  logic [STEP_W-1:0] step_r;

  logic [NUM_W-1:0]  dsh;
  logic              ge;
  logic [QUO_W-1:0]  q_nxt;
  logic              last_step;

  // restoring division, one quotient bit per cycle
  assign dsh       = NUM_W'({total, 1'b0}) << step_r;
  assign ge        = rem_r >= dsh;
  assign q_nxt     = {q_r[QUO_W-2:0], ge};
  assign last_step = (step_r == '0);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BLD_IDLE: if (start) state_nxt = BLD_READ;
      BLD_READ: state_nxt = BLD_ACC;
      BLD_ACC:  state_nxt = BLD_MUL;
      BLD_MUL:  state_nxt = BLD_DIV;
      BLD_DIV: begin
        if (last_step) begin
          state_nxt = (g_r == PIX_W'(BINS - 1)) ? BLD_IDLE : BLD_READ;
        end
      end
      default:  state_nxt = BLD_IDLE;
    endcase
  end

  always_comb begin
    busy        = (state_r != BLD_IDLE);
    bin_raddr   = g_r;
    map_wr.en   = 1'b0;
    map_wr.addr = g_r;
    map_wr.data = (total == '0) ? '0 : q_nxt;
    case (state_r)
      BLD_DIV: map_wr.en = last_step;
      default: map_wr.en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BLD_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BLD_IDLE: begin
        g_r   <= '0;
        run_r <= '0;
      end
      BLD_ACC: run_r <= run_r + bin_val;
      BLD_MUL: begin
        // running*510 + total
        rem_r  <= (NUM_W'(run_r) << 9) - (NUM_W'(run_r) << 1) + NUM_W'(total);
        q_r    <= '0;
        step_r <= STEP_W'(QUO_W - 1);
      end
      BLD_DIV: begin
        if (ge) rem_r <= rem_r - dsh;
        q_r    <= q_nxt;
        step_r <= step_r - 1'b1;
        if (last_step) g_r <= g_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/heq_outq.sv =====
module heq_outq import heq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  res_t       push_data,
  input  logic       out_stall,
  output logic       out_valid,
  output res_t       out_data,
  output logic [1:0] occ
);

  res_t       ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign out_data  = ent_r[rp_r];
  assign occ       = cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_r ^ push;
      rp_r  <= rp_r ^ pop;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== rtl/histogram_equalizer.sv =====
// 8-bit gray-level histogram equalizer. Each item carries an opcode and a
// pixel: count (0) adds the pixel to its bin, build (1) turns the histogram
// into a lookup table lut[g] = round(cdf[g]*255/total), map (2) returns
// lut[pixel] plus the sticky saturation flag as one result item, and clear (3)
// zeroes the bins, the pixel total and the flag (the table is kept). Count,
// clear and map items are taken one per cycle, back to back, unless a build
// runs or, for a map, the output queue has no room; a count is a read of
// the bin memory followed by a write in the next cycle, with the last write
// forwarded when the same bin comes again. Map reads the table memory and
// lands in a two-entry output queue, so a stalled result does not hold the
// input side until that queue is full. A build is the accept, then per bin a
// memory read, an accumulate, the scale step and a bit-serial divider, with
// the input stalled until the last bin is written. Counts beyond MAX_PIXELS
// are dropped and set the saturation flag. Bins are cleared at once through
// a per-bin valid vector, so there is no clearing pass after reset. Mapping
// before any build reads unwritten table entries and returns garbage.
module histogram_equalizer import heq_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_opcode,
  input  logic [PIX_W-1:0] in_pixel_value,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [PIX_W-1:0] out_equalized_pixel,
  output logic             out_count_saturated
);

  logic in_acc;
  logic cnt_acc, clr_acc, map_acc, bld_start;

  // running totals
  logic [CNT_W-1:0] total_r;
  logic             sat_r;

  // count pipeline: read issued at accept, write in the next cycle
  logic             s1_cnt_r;
  logic [PIX_W-1:0] rd_addr_r;
  logic [BINS-1:0]  bin_vld_r;
  logic             wb_vld_r;
  logic [PIX_W-1:0] wb_addr_r;
  logic [CNT_W-1:0] wb_data_r;

  logic [PIX_W-1:0] bin_raddr;
  logic [CNT_W-1:0] bin_rdata;
  logic [CNT_W-1:0] bin_val;
  logic [CNT_W-1:0] cnt_base;
  logic [CNT_W-1:0] cnt_new;

  // map path
  logic             m1_r;
  logic             m1_sat_r;
  logic [PIX_W-1:0] map_rdata;
  res_t             push_data;
  res_t             out_data;
  logic [1:0]       occ;
  logic [1:0]       inflight;
  logic             out_pop;
  logic             map_credit;

  // builder
  logic             bld_busy;
  logic [PIX_W-1:0] bld_raddr;
  map_wr_t          map_wr;

  assign in_acc    = in_valid && !in_stall;
  assign cnt_acc   = in_acc && (in_opcode == OP_COUNT) && (total_r < CNT_W'(MAX_PIXELS));
  assign clr_acc   = in_acc && (in_opcode == OP_CLEAR);
  assign map_acc   = in_acc && (in_opcode == OP_MAP);
  assign bld_start = in_acc && (in_opcode == OP_BUILD);

  // queue slots already promised: results in the queue plus one in flight
  assign out_pop    = out_valid && !out_stall;
  assign inflight   = occ + {1'b0, m1_r};
  assign map_credit = (inflight < 2'd2) || ((inflight == 2'd2) && out_pop);

  assign in_stall = bld_busy || ((in_opcode == OP_MAP) && !map_credit);

  // --- bin memory ---
  assign bin_raddr = bld_busy ? bld_raddr : in_pixel_value;
  assign bin_val   = bin_vld_r[rd_addr_r] ? bin_rdata : '0;
  assign cnt_base  = (wb_vld_r && (wb_addr_r == rd_addr_r)) ? wb_data_r : bin_val;
  assign cnt_new   = cnt_base + 1'b1;

  heq_ram #(.WIDTH(CNT_W), .DEPTH(BINS)) u_bin_ram (
    .clk   (clk),
    .we    (s1_cnt_r),
    .waddr (rd_addr_r),
    .wdata (cnt_new),
    .raddr (bin_raddr),
    .rdata (bin_rdata)
  );

  always_ff @(posedge clk) begin
    rd_addr_r <= bin_raddr;
    wb_addr_r <= rd_addr_r;
    wb_data_r <= cnt_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r   <= '0;
      sat_r     <= 1'b0;
      s1_cnt_r  <= 1'b0;
      wb_vld_r  <= 1'b0;
      bin_vld_r <= '0;
      m1_r      <= 1'b0;
    end else begin
      s1_cnt_r <= cnt_acc;
      m1_r     <= map_acc;
      // a clear wins over the write of a count taken just before it
      wb_vld_r <= s1_cnt_r && !clr_acc;
      if (clr_acc) begin
        total_r   <= '0;
        sat_r     <= 1'b0;
        bin_vld_r <= '0;
      end else begin
        if (s1_cnt_r) bin_vld_r[rd_addr_r] <= 1'b1;
        if (cnt_acc) begin
          total_r <= total_r + 1'b1;
        end else if (in_acc && (in_opcode == OP_COUNT)) begin
          sat_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (map_acc) m1_sat_r <= sat_r;
  end

  // --- table build ---
  heq_builder u_builder (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (bld_start),
    .total     (total_r),
    .bin_val   (bin_val),
    .busy      (bld_busy),
    .bin_raddr (bld_raddr),
    .map_wr    (map_wr)
  );

  // --- lookup table memory ---
  heq_ram #(.WIDTH(PIX_W), .DEPTH(BINS)) u_map_ram (
    .clk   (clk),
    .we    (map_wr.en),
    .waddr (map_wr.addr),
    .wdata (map_wr.data),
    .raddr (in_pixel_value),
    .rdata (map_rdata)
  );

  // --- result queue ---
  assign push_data.eq  = map_rdata;
  assign push_data.sat = m1_sat_r;

  heq_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (m1_r),
    .push_data (push_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .occ       (occ)
  );

  assign out_equalized_pixel = out_data.eq;
  assign out_count_saturated = out_data.sat;

endmodule

// ===== rtl/heq_checker.sv =====
`include "assert_macros.svh"

module heq_checker import heq_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic [1:0]       in_opcode,
  input logic             out_valid,
  input logic             out_stall,
  input logic [PIX_W-1:0] out_equalized_pixel,
  input logic             out_count_saturated
);

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  `HEQ_ASSERT_HOLD(a_out_pix_hold, clk, rst_n, out_valid, out_stall, out_equalized_pixel)
  `HEQ_ASSERT_HOLD(a_out_sat_hold, clk, rst_n, out_valid, out_stall, out_count_saturated)
  `HEQ_ASSERT(a_res_from_map, clk, rst_n, $rose(out_valid) |-> $past(in_acc && (in_opcode == OP_MAP), 2))
  `HEQ_ASSERT(a_build_holds_input, clk, rst_n, (in_acc && (in_opcode == OP_BUILD)) |=> in_stall)

endmodule

bind histogram_equalizer heq_checker u_heq_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .in_opcode           (in_opcode),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_equalized_pixel (out_equalized_pixel),
  .out_count_saturated (out_count_saturated)
);

// ===== dv/tb_histogram_equalizer.sv =====
module tb_histogram_equalizer;
  import heq_pkg::*;

  // Drain wait after the last result, longer than the map path depth.
  localparam int DRAIN_CYCLES = 32;
  // Long receiver hold-off, long enough to fill the two-entry result queue.
  localparam int HOLD_CYCLES  = 300;
  // A run's time goes mostly to builds, and the limit still covers every
  // item being a build.
  localparam longint TIMEOUT_TICKS = 64'd8 * 64'd4_000_000;
  localparam int RANDOM_ITEMS = 1200;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       in_opcode = OP_COUNT;
  logic [PIX_W-1:0] in_pixel_value = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [PIX_W-1:0] out_equalized_pixel;
  logic             out_count_saturated;

  histogram_equalizer uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_pixel_value      (in_pixel_value),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_equalized_pixel (out_equalized_pixel),
    .out_count_saturated (out_count_saturated)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Sideband that travels with the item on the input: when row_fixed is set
  // the typed-in result replaces the predicted one.
  logic row_fixed = 1'b0;
  res_t row_want = '0;

  bit          idle_on = 1'b1;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int          hold_left = 0;

  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_builds = 0;
  int n_drops = 0;
  int n_holds = 0;

  // Predicted histogram, pixel total, sticky flag and lookup table.
  int unsigned      bin_tally [BINS];
  int unsigned      tally_total = 0;
  bit               sat_seen = 1'b0;
  logic [PIX_W-1:0] eq_lut [BINS];

  // Map results still owed by the block, oldest first.
  res_t pending_pixels [$];

  initial begin
    foreach (bin_tally[g]) bin_tally[g] = 0;
    foreach (eq_lut[g]) eq_lut[g] = '0;
  end

  // Receiver: random stalls, plus a long hold-off counted here on request.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
      n_holds   <= n_holds + 1;
    end else begin
      out_stall <= idle_on && ($urandom_range(99) < 6);
    end
  end

  // Predictor and scoreboard. Input side is handled first: a map result can
  // never leave in the cycle its item is taken.
  always @(posedge clk) begin
    longint unsigned run;
    longint unsigned tot;
    longint unsigned q;
    res_t want;
    res_t got;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        n_items++;
        case (op_t'(in_opcode))
          OP_COUNT: begin
            if (tally_total < MAX_PIXELS) begin
              bin_tally[in_pixel_value]++;
              tally_total++;
            end else begin
              // counter full: drop and latch the flag
              sat_seen = 1'b1;
              n_drops++;
            end
          end
          OP_BUILD: begin
            run = 0;
            tot = tally_total;
            for (int g = 0; g < BINS; g++) begin
              run += bin_tally[g];
              if (tot == 0) begin
                eq_lut[g] = '0;
              end else begin
                // round(cdf*255/total) in integers
                q = (run * 510 + tot) / (2 * tot);
                eq_lut[g] = (q > 255) ? 8'd255 : q[PIX_W-1:0];
              end
            end
            n_builds++;
          end
          OP_MAP: begin
            want.eq  = eq_lut[in_pixel_value];
            want.sat = sat_seen;
            if (row_fixed) want = row_want;
            pending_pixels.push_back(want);
          end
          OP_CLEAR: begin
            foreach (bin_tally[g]) bin_tally[g] = 0;
            tally_total = 0;
            sat_seen = 1'b0;
          end
        endcase
      end
      if (out_valid && !out_stall) begin
        n_results++;
        got.eq  = out_equalized_pixel;
        got.sat = out_count_saturated;
        if (pending_pixels.size() == 0) begin
          $display("%0t: unexpected result: expected none, got eq=%0d sat=%0d",
                   $time, got.eq, got.sat);
          errors++;
        end else begin
          want = pending_pixels.pop_front();
          if (got.eq !== want.eq) begin
            $display("%0t: equalized_pixel mismatch: expected %0d, got %0d",
                     $time, want.eq, got.eq);
            errors++;
          end
          if (got.sat !== want.sat) begin
            $display("%0t: count_saturated mismatch: expected %0d, got %0d",
                     $time, want.sat, got.sat);
            errors++;
          end
        end
      end
    end
  end

  // Offer one item at the falling edge and hold it until taken.
  task automatic send(input op_t op, input logic [PIX_W-1:0] pix,
                      input bit fixed, input res_t want);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_pixel_value <= pix;
    row_fixed      <= fixed;
    row_want       <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid, then wait until every owed result has come back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  typedef struct {
    op_t              op;
    logic [PIX_W-1:0] pix;
    int               reps;
    bit               rnd;    // random pixel on each repeat
    bit               fixed;  // result typed in below
    logic [PIX_W-1:0] eq;
    logic             sat;
  } plan_row_t;

  plan_row_t plan [23];

  initial begin
    int n;
    int mode;
    int seg;
    int rnd_items;
    logic [PIX_W-1:0] base;
    logic [PIX_W-1:0] pix;
    op_t op;

    plan = '{
      // empty histogram right after reset: every entry becomes zero
      '{OP_BUILD, 8'd0,   1, 0, 0, 8'd0,   1'b0},
      '{OP_MAP,   8'd0,   1, 0, 1, 8'd0,   1'b0},
      '{OP_MAP,   8'd255, 1, 0, 1, 8'd0,   1'b0},
      '{OP_COUNT, 8'd0,   1, 0, 0, 8'd0,   1'b0},
      '{OP_COUNT, 8'd255, 1, 0, 0, 8'd0,   1'b0},
      '{OP_COUNT, 8'd128, 1, 0, 0, 8'd0,   1'b0},
      '{OP_BUILD, 8'd0,   1, 0, 0, 8'd0,   1'b0},
      '{OP_MAP,   8'd0,   1, 0, 0, 8'd0,   1'b0},
      '{OP_MAP,   8'd128, 1, 0, 0, 8'd0,   1'b0},
      // top bin always holds the whole total
      '{OP_MAP,   8'd255, 1, 0, 1, 8'd255, 1'b0},
      // clear keeps the table
      '{OP_CLEAR, 8'd0,   1, 0, 0, 8'd0,   1'b0},
      '{OP_MAP,   8'd255, 1, 0, 1, 8'd255, 1'b0},
      // build after clear sees an empty histogram
      '{OP_BUILD, 8'd0,   1, 0, 0, 8'd0,   1'b0},
      '{OP_MAP,   8'd255, 1, 0, 1, 8'd0,   1'b0},
      '{OP_COUNT, 8'd255, 1, 0, 0, 8'd0,   1'b0},
      '{OP_BUILD, 8'd0,   1, 0, 0, 8'd0,   1'b0},
      '{OP_MAP,   8'd254, 1, 0, 1, 8'd0,   1'b0},
      // rebuild from a single pixel in the top bin
      '{OP_BUILD, 8'd0,   1, 0, 0, 8'd0,   1'b0},
      '{OP_MAP,   8'd255, 1, 0, 1, 8'd255, 1'b0},
      '{OP_MAP,   8'd0,   1, 0, 0, 8'd0,   1'b0},
      // clear keeps the table built from that one pixel
      '{OP_CLEAR, 8'd0,   1, 0, 0, 8'd0,   1'b0},
      '{OP_MAP,   8'd255, 1, 0, 1, 8'd255, 1'b0},
      '{OP_MAP,   8'd0,   1, 0, 0, 8'd0,   1'b0}
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed rows.
    foreach (plan[r]) begin
      if (plan[r].op == OP_CLEAR) drain();
      idle_on = (plan[r].reps == 1);
      for (int k = 0; k < plan[r].reps; k++) begin
        pix = plan[r].rnd ? 8'($urandom) : plan[r].pix;
        send(plan[r].op, pix, plan[r].fixed, '{eq: plan[r].eq, sat: plan[r].sat});
      end
    end
    idle_on = 1'b1;

    // Random part: mostly clear/count/build/map sequences, some noise.
    seg = 0;
    rnd_items = 0;
    while (rnd_items < RANDOM_ITEMS) begin
      idle_on = !(seg >= 12 && seg < 18);
      // sender pause: let everything owed come back first
      if (seg % 10 == 9) drain();
      if (seg == 5 || seg == 25 || $urandom_range(9) < 7) begin
        if ($urandom_range(2) == 0) begin
          send(OP_CLEAR, 8'($urandom), 0, '0);
          rnd_items++;
        end
        n    = $urandom_range(60, 1);
        mode = $urandom_range(2);
        base = 8'($urandom);
        repeat (n) begin
          case (mode)
            0:       pix = 8'($urandom);
            1:       pix = base + 8'($urandom_range(15));
            default: pix = $urandom_range(1) ? 8'hFF : 8'h00;
          endcase
          send(OP_COUNT, pix, 0, '0);
        end
        rnd_items += n;
        send(OP_BUILD, 8'($urandom), 0, '0);
        rnd_items++;
        n = $urandom_range(40, 1);
        if (seg == 5 || seg == 25) begin
          // receiver holds off while maps keep coming: queue fills, input stalls
          hold_req++;
          n = 40;
        end
        repeat (n) send(OP_MAP, 8'($urandom), 0, '0);
        rnd_items += n;
      end else begin
        n = $urandom_range(20, 1);
        repeat (n) begin
          op = op_t'($urandom_range(3));
          if (op == OP_BUILD && $urandom_range(3) != 0) op = OP_COUNT;
          send(op, 8'($urandom), 0, '0);
        end
        rnd_items += n;
      end
      seg++;
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d items in %0d sequences: %0d builds, %0d map results,",
             n_items, seg, n_builds, n_results);
    $display("%0d dropped counts past full, %0d long receiver hold-offs, %0d errors",
             n_drops, n_holds, errors);
    if (errors == 0) begin
      $display("histogram_equalizer regression: pass");
    end else begin
      $display("histogram_equalizer regression: fail");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_TICKS);
    $display("%0t: timeout, %0d results still owed", $time, pending_pixels.size());
    $display("histogram_equalizer regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/heq_pkg.sv
rtl/heq_ram.sv
rtl/heq_builder.sv
rtl/heq_outq.sv
rtl/histogram_equalizer.sv
rtl/heq_checker.sv
dv/tb_histogram_equalizer.sv
